// ===== rtl/hba_pkg.sv =====
`default_nettype none
package hba_pkg;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_GEOM  = 2'd2,
		ACT_END   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNDER    = 2'd1,
		ST_OVER     = 2'd2,
		ST_NO_GROUP = 2'd3
	} status_t;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam int NUM_ROWS = 3;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         row;
		logic signed [31:0] coef_0;
		logic signed [31:0] coef_1;
		logic signed [31:0] coef_2;
		logic signed [31:0] coef_3;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         level;
		logic               has_geometry;
		logic signed [31:0] out_min_x;
		logic signed [31:0] out_min_y;
		logic signed [31:0] out_min_z;
		logic signed [31:0] out_max_x;
		logic signed [31:0] out_max_y;
		logic signed [31:0] out_max_z;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] lo_z;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
		logic signed [31:0] hi_z;
	} box_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;    // latch the input transaction
		logic       load_row;   // write matrix row
		logic       corner_mul; // multiply stage for corner
		logic [2:0] corner;
		logic       corner_acc; // sum and widen accumulator
		logic       acc_init;   // seed accumulator from top entry
		logic       push;       // write empty box at top
		logic       pop_rd;     // read popped entry
		logic       merge;      // widen parent with popped box
		logic       top_wr;     // write accumulator back to top
	} hba_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/hba_datapath.sv =====
`default_nettype none
module hba_datapath #(
	parameter int ADDR_W = 6
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire hba_pkg::hba_cmd_t cmd,
	input  wire hba_pkg::in_item_t item,
	input  wire [ADDR_W-1:0]    rd_addr,
	input  wire [ADDR_W-1:0]    wr_addr,
	output hba_pkg::in_item_t   item_q,
	output hba_pkg::box_t       rd_box_q
);

	logic signed [31:0] mat_q [12];
	hba_pkg::box_t mem [2**ADDR_W];
	logic signed [63:0] prod_s1 [9];
	logic signed [31:0] xs, ys, zs;
	logic signed [31:0] pt [3];
	hba_pkg::box_t wr_data;
	hba_pkg::box_t empty_box;
	hba_pkg::box_t acc_q;

	// floor shift then sum with translation, saturate
	function automatic logic signed [31:0] row_sum(input logic signed [63:0] a,
		input logic signed [63:0] b, input logic signed [63:0] c,
		input logic signed [31:0] t);
		logic signed [49:0] s;
		s = 50'(a >>> 16) + 50'(b >>> 16) + 50'(c >>> 16) + 50'(t);
		if (s > 50'(hba_pkg::Q_MAX)) return hba_pkg::Q_MAX;
		else if (s < 50'(hba_pkg::Q_MIN)) return hba_pkg::Q_MIN;
		else return s[31:0];
	endfunction

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
	end

	// matrix rows, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 12; i++) mat_q[i] <= '0;
		end else if (cmd.load_row) begin
			for (int r = 0; r < hba_pkg::NUM_ROWS; r++) begin
				if (item_q.row == 2'(r)) begin
					mat_q[4*r]   <= item_q.coef_0;
					mat_q[4*r+1] <= item_q.coef_1;
					mat_q[4*r+2] <= item_q.coef_2;
					mat_q[4*r+3] <= item_q.coef_3;
				end
			end
		end
	end

	// corner select
	always_comb begin
		xs = cmd.corner[0] ? item_q.box_min_x : item_q.box_max_x;
		ys = cmd.corner[1] ? item_q.box_min_y : item_q.box_max_y;
		zs = cmd.corner[2] ? item_q.box_min_z : item_q.box_max_z;
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (cmd.corner_mul) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[3*r]   <= 64'(mat_q[4*r]) * 64'(xs);
				prod_s1[3*r+1] <= 64'(mat_q[4*r+1]) * 64'(ys);
				prod_s1[3*r+2] <= 64'(mat_q[4*r+2]) * 64'(zs);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++)
			pt[r] = row_sum(prod_s1[3*r], prod_s1[3*r+1], prod_s1[3*r+2], mat_q[4*r+3]);
	end

	// accumulator: seeded from top entry or parent entry, widened per point
	always_ff @(posedge clk) begin
		if (cmd.acc_init) acc_q <= rd_box_q;
		else if (cmd.corner_acc) begin
			if (pt[0] < acc_q.lo_x) acc_q.lo_x <= pt[0];
			if (pt[1] < acc_q.lo_y) acc_q.lo_y <= pt[1];
			if (pt[2] < acc_q.lo_z) acc_q.lo_z <= pt[2];
			if (pt[0] > acc_q.hi_x) acc_q.hi_x <= pt[0];
			if (pt[1] > acc_q.hi_y) acc_q.hi_y <= pt[1];
			if (pt[2] > acc_q.hi_z) acc_q.hi_z <= pt[2];
		end else if (cmd.merge) begin
			// acc holds parent, rd_box_q holds popped child
			if (rd_box_q.lo_x < acc_q.lo_x) acc_q.lo_x <= rd_box_q.lo_x;
			if (rd_box_q.lo_y < acc_q.lo_y) acc_q.lo_y <= rd_box_q.lo_y;
			if (rd_box_q.lo_z < acc_q.lo_z) acc_q.lo_z <= rd_box_q.lo_z;
			if (rd_box_q.hi_x > acc_q.hi_x) acc_q.hi_x <= rd_box_q.hi_x;
			if (rd_box_q.hi_y > acc_q.hi_y) acc_q.hi_y <= rd_box_q.hi_y;
			if (rd_box_q.hi_z > acc_q.hi_z) acc_q.hi_z <= rd_box_q.hi_z;
		end
	end

	always_comb begin
		empty_box = '{hba_pkg::Q_MAX, hba_pkg::Q_MAX, hba_pkg::Q_MAX,
			hba_pkg::Q_MIN, hba_pkg::Q_MIN, hba_pkg::Q_MIN};
		wr_data = cmd.push ? empty_box : acc_q;
	end

	// stack memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.push || cmd.top_wr) mem[wr_addr] <= wr_data;
		rd_box_q <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/hba_ctrl.sv =====
`default_nettype none
module hba_ctrl #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int CNT_W  = 7
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire hba_pkg::in_item_t item_q,
	input  wire hba_pkg::box_t  rd_box_q,
	output logic                busy,
	output hba_pkg::hba_cmd_t   cmd,
	output logic [ADDR_W-1:0]   rd_addr,
	output logic [ADDR_W-1:0]   wr_addr,
	output logic                done,
	output hba_pkg::out_item_t  result
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DECODE = 10'b0000000010,
		S_GRD    = 10'b0000000100,
		S_GMUL   = 10'b0000001000,
		S_GWB    = 10'b0000010000,
		S_PRD    = 10'b0000100000,
		S_PCHK   = 10'b0001000000,
		S_MRD    = 10'b0010000000,
		S_MWB    = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0] k_q;
	logic [1:0] st_q;
	logic geo_q;
	hba_pkg::box_t box_q;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// command decode per state
	always_comb begin
		cmd = '0;
		cmd.capture = start && !busy;
		cmd.corner = k_q[2:0];
		rd_addr = ADDR_W'(cnt_q - CNT_W'(1));
		wr_addr = ADDR_W'(cnt_q - CNT_W'(1));
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_DECODE;
			S_DECODE: begin
				unique case (hba_pkg::action_t'(item_q.action))
					hba_pkg::ACT_BEGIN: begin
						wr_addr = ADDR_W'(cnt_q);
						cmd.push = (cnt_q < CNT_W'(DEPTH));
						state_d = S_DONE;
					end
					hba_pkg::ACT_LOAD: begin
						cmd.load_row = 1'b1;
						state_d = S_DONE;
					end
					hba_pkg::ACT_GEOM: state_d = (cnt_q == '0) ? S_DONE : S_GRD;
					default: state_d = (cnt_q == '0) ? S_DONE : S_PRD;
				endcase
			end
			S_GRD: begin
				cmd.acc_init = 1'b1;
				cmd.corner_mul = 1'b1;
				state_d = S_GMUL;
			end
			S_GMUL: begin
				cmd.corner_acc = 1'b1;
				cmd.corner_mul = (k_q < 4'd8);
				if (k_q == 4'd8) state_d = S_GWB;
			end
			S_GWB: begin
				cmd.top_wr = 1'b1;
				state_d = S_DONE;
			end
			S_PRD: state_d = S_PCHK;
			S_PCHK: begin
				rd_addr = ADDR_W'(cnt_q - CNT_W'(2));
				state_d = (rd_box_q.hi_x >= rd_box_q.lo_x && cnt_q > CNT_W'(1)) ?
					S_MRD : S_DONE;
			end
			S_MRD: begin
				// count already decremented: popped child sits at cnt
				rd_addr = ADDR_W'(cnt_q);
				cmd.acc_init = 1'b1;
				state_d = S_MWB;
			end
			S_MWB: begin
				rd_addr = ADDR_W'(cnt_q - CNT_W'(1));
				cmd.merge = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				wr_addr = ADDR_W'(cnt_q - CNT_W'(1));
				cmd.top_wr = 1'b0;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// merge write-back happens in the cycle after S_MWB (S_DONE)
	logic merge_wb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			st_q <= '0;
			geo_q <= 1'b0;
			merge_wb_q <= 1'b0;
		end else begin
			state_q <= state_d;
			merge_wb_q <= (state_q == S_MWB);
			if (state_q == S_GRD) k_q <= 4'd1;
			else if (state_q == S_GMUL) k_q <= k_q + 4'd1;
			else if (state_q == S_DECODE) k_q <= '0;
			if (state_q == S_DECODE) begin
				geo_q <= 1'b0;
				st_q <= hba_pkg::ST_OK;
				unique case (hba_pkg::action_t'(item_q.action))
					hba_pkg::ACT_BEGIN:
						if (cnt_q < CNT_W'(DEPTH)) cnt_q <= cnt_q + CNT_W'(1);
						else st_q <= hba_pkg::ST_OVER;
					hba_pkg::ACT_LOAD: ;
					hba_pkg::ACT_GEOM:
						if (cnt_q == '0) st_q <= hba_pkg::ST_NO_GROUP;
					default:
						if (cnt_q == '0) st_q <= hba_pkg::ST_UNDER;
				endcase
			end
			if (state_q == S_PCHK) begin
				cnt_q <= cnt_q - CNT_W'(1);
				geo_q <= (rd_box_q.hi_x >= rd_box_q.lo_x);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PCHK) box_q <= rd_box_q;
	end

	// write back merged parent (cnt already decremented: parent at cnt-1)
	// done through the datapath top write in S_DONE
	always_comb begin
		result.status = st_q;
		result.level = 7'(cnt_q);
		result.has_geometry = geo_q;
		result.out_min_x = geo_q ? box_q.lo_x : '0;
		result.out_min_y = geo_q ? box_q.lo_y : '0;
		result.out_min_z = geo_q ? box_q.lo_z : '0;
		result.out_max_x = geo_q ? box_q.hi_x : '0;
		result.out_max_y = geo_q ? box_q.hi_y : '0;
		result.out_max_z = geo_q ? box_q.hi_z : '0;
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(DEPTH))
		else $error("stack count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GMUL) |-> (k_q >= 4'd1 && k_q <= 4'd8))
		else $error("corner index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		merge_wb_q |-> !cmd.push)
		else $error("push during merge");

endmodule
`default_nettype wire

// ===== rtl/hierarchical_bbox_accumulator_top.sv =====
`default_nettype none
// Sequence from accept to done strobe: begin/load decode, then done; geometry seeds the
// accumulator, takes eight corners one per cycle through the multiplier stage, then writes
// back; end group decodes (underflow), pops (pop), or pops and merges into the parent.
// One transaction at a time: start is accepted only while busy is low.
// Reset: arst_n clears stack count, controller state and matrix rows to zero; stack
// entries are not cleared. The receiver cannot stall: done lasts exactly one cycle.
module hierarchical_bbox_accumulator_top #(
	parameter int STACK_DEPTH = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire hba_pkg::in_item_t in_item,
	output logic               busy,
	output logic               done,
	output hba_pkg::out_item_t result
);

	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

	hba_pkg::hba_cmd_t cmd, cmd_c;
	hba_pkg::in_item_t item_q;
	hba_pkg::box_t rd_box_q;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic mwb_q;

	hba_ctrl #(.DEPTH(STACK_DEPTH), .ADDR_W(ADDR_W), .CNT_W(CNT_W)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.item_q(item_q), .rd_box_q(rd_box_q), .busy(busy),
		.cmd(cmd_c), .rd_addr(rd_addr), .wr_addr(wr_addr), .done(done),
		.result(result)
	);

	// merged parent is written in the cycle after the merge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mwb_q <= 1'b0;
		else mwb_q <= cmd_c.merge;
	end

	always_comb begin
		cmd = cmd_c;
		if (mwb_q) cmd.top_wr = 1'b1;
	end

	hba_datapath #(.ADDR_W(ADDR_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(in_item), .rd_addr(rd_addr),
		.wr_addr(wr_addr), .item_q(item_q), .rd_box_q(rd_box_q)
	);

endmodule
`default_nettype wire

// ===== verif/hierarchical_bbox_accumulator_top_test.sv =====
module hierarchical_bbox_accumulator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int N_RANDOM = 1450;
	localparam int QUIET_TAIL = 100;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	hba_pkg::in_item_t in_item;
	logic busy;
	logic done;
	hba_pkg::out_item_t result;

	hierarchical_bbox_accumulator_top #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_item(in_item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	hba_pkg::in_item_t pending_items[$];
	hba_pkg::out_item_t expected_boxes[$];
	int errors = 0;
	int idle_left = 0;
	int cycles = 0;

	// predictor state
	hba_pkg::box_t group_stack[DEPTH];
	int group_depth = 0;
	logic signed [31:0] xform_mtx[3][4] = '{default: '0};

	function automatic logic signed [31:0] xform_axis(int r, logic signed [31:0] x,
		logic signed [31:0] y, logic signed [31:0] z);
		longint s;
		s = ((longint'(xform_mtx[r][0]) * longint'(x)) >>> 16)
		  + ((longint'(xform_mtx[r][1]) * longint'(y)) >>> 16)
		  + ((longint'(xform_mtx[r][2]) * longint'(z)) >>> 16)
		  + longint'(xform_mtx[r][3]);
		if (s > longint'(hba_pkg::Q_MAX)) s = longint'(hba_pkg::Q_MAX);
		if (s < longint'(hba_pkg::Q_MIN)) s = longint'(hba_pkg::Q_MIN);
		return s[31:0];
	endfunction

	task automatic widen_group(int t, logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] pz);
		if (px < group_stack[t].lo_x) group_stack[t].lo_x = px;
		if (py < group_stack[t].lo_y) group_stack[t].lo_y = py;
		if (pz < group_stack[t].lo_z) group_stack[t].lo_z = pz;
		if (px > group_stack[t].hi_x) group_stack[t].hi_x = px;
		if (py > group_stack[t].hi_y) group_stack[t].hi_y = py;
		if (pz > group_stack[t].hi_z) group_stack[t].hi_z = pz;
	endtask

	// compute the expected result of one transaction and update predictor state
	task automatic predict_bbox(hba_pkg::in_item_t it);
		hba_pkg::out_item_t r;
		logic signed [31:0] x, y, z;
		int t;
		r = '0;
		r.status = hba_pkg::ST_OK;
		case (hba_pkg::action_t'(it.action))
			hba_pkg::ACT_BEGIN: begin
				if (group_depth >= DEPTH) begin
					r.status = hba_pkg::ST_OVER;
				end else begin
					group_stack[group_depth] = '{hba_pkg::Q_MAX, hba_pkg::Q_MAX,
						hba_pkg::Q_MAX, hba_pkg::Q_MIN, hba_pkg::Q_MIN, hba_pkg::Q_MIN};
					group_depth++;
				end
			end
			hba_pkg::ACT_LOAD: begin
				if (it.row < hba_pkg::NUM_ROWS) begin
					xform_mtx[it.row][0] = it.coef_0;
					xform_mtx[it.row][1] = it.coef_1;
					xform_mtx[it.row][2] = it.coef_2;
					xform_mtx[it.row][3] = it.coef_3;
				end
			end
			hba_pkg::ACT_GEOM: begin
				if (group_depth == 0) begin
					r.status = hba_pkg::ST_NO_GROUP;
				end else begin
					t = group_depth - 1;
					for (int k = 0; k < 8; k++) begin
						x = k[0] ? it.box_min_x : it.box_max_x;
						y = k[1] ? it.box_min_y : it.box_max_y;
						z = k[2] ? it.box_min_z : it.box_max_z;
						widen_group(t, xform_axis(0, x, y, z), xform_axis(1, x, y, z),
							xform_axis(2, x, y, z));
					end
				end
			end
			default: begin
				if (group_depth == 0) begin
					r.status = hba_pkg::ST_UNDER;
				end else begin
					group_depth--;
					t = group_depth;
					if (group_stack[t].hi_x >= group_stack[t].lo_x) begin
						r.has_geometry = 1'b1;
						r.out_min_x = group_stack[t].lo_x;
						r.out_min_y = group_stack[t].lo_y;
						r.out_min_z = group_stack[t].lo_z;
						r.out_max_x = group_stack[t].hi_x;
						r.out_max_y = group_stack[t].hi_y;
						r.out_max_z = group_stack[t].hi_z;
						if (t > 0) begin
							widen_group(t - 1, r.out_min_x, r.out_min_y, r.out_min_z);
							widen_group(t - 1, r.out_max_x, r.out_max_y, r.out_max_z);
						end
					end
				end
			end
		endcase
		r.level = group_depth[6:0];
		expected_boxes.push_back(r);
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $realtime, name, exp_v,
				act_v);
			errors++;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: one transaction per accept, random idle bursts except in the tail
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			in_item <= '0;
		end else begin
			if (start && !busy) predict_bbox(in_item);
			if (start && busy) begin
				start <= 1'b1;
			end else if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_item <= pending_items.pop_front();
				start <= 1'b1;
				if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
					idle_left <= $urandom_range(1, 7);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_boxes.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $realtime, result);
				errors++;
			end else begin
				hba_pkg::out_item_t e;
				e = expected_boxes.pop_front();
				check_field("status", e.status, result.status);
				check_field("level", e.level, result.level);
				check_field("has_geometry", e.has_geometry, result.has_geometry);
				check_field("out_min_x", e.out_min_x, result.out_min_x);
				check_field("out_min_y", e.out_min_y, result.out_min_y);
				check_field("out_min_z", e.out_min_z, result.out_min_z);
				check_field("out_max_x", e.out_max_x, result.out_max_x);
				check_field("out_max_y", e.out_max_y, result.out_max_y);
				check_field("out_max_z", e.out_max_z, result.out_max_z);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("hierarchical_bbox_accumulator_top regression: fail");
			$finish;
		end
	end

	function automatic hba_pkg::in_item_t make_item(hba_pkg::action_t a, logic [1:0] r);
		hba_pkg::in_item_t it;
		it = '0;
		it.action = a;
		it.row = r;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_coef();
		if ($urandom_range(0, 1)) return $urandom();
		return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(0, 9) < 3) return $urandom();
		return $signed($urandom_range(0, 32'h7D00000)) - 32'sh3E80000;
	endfunction

	task automatic add_load(logic [1:0] r, logic signed [31:0] c0, logic signed [31:0] c1,
		logic signed [31:0] c2, logic signed [31:0] c3);
		hba_pkg::in_item_t it;
		it = make_item(hba_pkg::ACT_LOAD, r);
		it.coef_0 = c0;
		it.coef_1 = c1;
		it.coef_2 = c2;
		it.coef_3 = c3;
		pending_items.push_back(it);
	endtask

	task automatic add_geom(logic signed [31:0] a, logic signed [31:0] b);
		hba_pkg::in_item_t it;
		it = make_item(hba_pkg::ACT_GEOM, 2'd0);
		it.box_min_x = a; it.box_min_y = a; it.box_min_z = a;
		it.box_max_x = b; it.box_max_y = b; it.box_max_z = b;
		pending_items.push_back(it);
	endtask

	task automatic build_stimulus();
		hba_pkg::in_item_t it;
		int d;
		int pick;
		// directed: defined matrix first, then each special case
		add_load(2'd0, 32'sh10000, 0, 0, 32'sh8000);
		add_load(2'd1, 0, 32'sh10000, 0, -32'sh8000);
		add_load(2'd2, 0, 0, 32'sh10000, 0);
		pending_items.push_back(make_item(hba_pkg::ACT_END, 2'd0));      // underflow
		add_geom(32'sh10000, 32'sh20000);                                  // no open group
		pending_items.push_back(make_item(hba_pkg::ACT_BEGIN, 2'd0));
		pending_items.push_back(make_item(hba_pkg::ACT_END, 2'd0));      // empty box
		pending_items.push_back(make_item(hba_pkg::ACT_BEGIN, 2'd0));
		pending_items.push_back(make_item(hba_pkg::ACT_BEGIN, 2'd0));
		add_geom(-32'sh10000, 32'sh30000);
		add_geom(32'sh50000, -32'sh20000);                                 // reversed box
		pending_items.push_back(make_item(hba_pkg::ACT_END, 2'd0));      // merge
		add_load(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_load(2'd0, hba_pkg::Q_MAX, hba_pkg::Q_MIN, hba_pkg::Q_MAX, hba_pkg::Q_MAX);
		add_load(2'd1, hba_pkg::Q_MIN, hba_pkg::Q_MIN, hba_pkg::Q_MIN, hba_pkg::Q_MIN);
		add_load(2'd2, hba_pkg::Q_MAX, hba_pkg::Q_MAX, hba_pkg::Q_MAX, hba_pkg::Q_MIN);
		add_geom(hba_pkg::Q_MIN, hba_pkg::Q_MAX);                          // saturation
		add_geom(0, 0);
		pending_items.push_back(make_item(hba_pkg::ACT_END, 2'd0));
		// fill the stack, overflow, then drain
		for (int i = 0; i <= DEPTH; i++)
			pending_items.push_back(make_item(hba_pkg::ACT_BEGIN, 2'd0));
		add_geom(-32'sh1, 32'sh1);
		for (int i = 0; i < DEPTH; i++)
			pending_items.push_back(make_item(hba_pkg::ACT_END, 2'd0));
		add_load(2'd0, 32'sh10000, 32'sh4000, 0, 32'sh100);
		add_load(2'd1, -32'sh8000, 32'sh10000, 32'sh2000, 0);
		add_load(2'd2, 0, 32'sh3000, -32'sh10000, -32'sh100);

		// random: mostly well-formed nesting with random content
		d = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			it.action = 2'($urandom());
			it.row = 2'($urandom());
			it.coef_0 = rand_coef();
			it.coef_1 = rand_coef();
			it.coef_2 = rand_coef();
			it.coef_3 = rand_coef();
			it.box_min_x = rand_coord();
			it.box_min_y = rand_coord();
			it.box_min_z = rand_coord();
			it.box_max_x = rand_coord();
			it.box_max_y = rand_coord();
			it.box_max_z = rand_coord();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// noise: action and row fully random
			end else if (pick < 16) begin
				it.action = hba_pkg::ACT_LOAD;
				it.row = 2'($urandom_range(0, 2));
			end else if (pick < 56) begin
				it.action = (d == 0) ? hba_pkg::ACT_BEGIN : hba_pkg::ACT_GEOM;
			end else if (pick < 78) begin
				it.action = (d < 6 || $urandom_range(0, 3) == 0) ?
					hba_pkg::ACT_BEGIN : hba_pkg::ACT_END;
			end else begin
				it.action = hba_pkg::ACT_END;
			end
			if (it.action == hba_pkg::ACT_BEGIN && d < DEPTH) d++;
			if (it.action == hba_pkg::ACT_END && d > 0) d--;
			pending_items.push_back(it);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_items.size() > 0 || start || expected_boxes.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_boxes.size() == 0) begin
			$display("hierarchical_bbox_accumulator_top regression: pass");
		end else begin
			$display("hierarchical_bbox_accumulator_top regression: fail");
		end
		$finish;
	end
endmodule
